### rtl/bftr_pkg.sv
// Shared types, constants and helpers for the bitmap font text renderer.
// Used by the controller, the datapath and the top level; depends on nothing.
package bftr_pkg;

  // Font geometry. The row count and the store depth must be powers of two.
  localparam int GLYPH_ROWS  = 16;
  localparam int GLYPH_COUNT = 256;
  localparam int FONT_DEPTH  = GLYPH_COUNT * GLYPH_ROWS;
  localparam int FONT_AW     = $clog2(FONT_DEPTH);
  localparam int ROW_W       = $clog2(GLYPH_ROWS);

  // Fixed field widths and drawing constants.
  localparam int CODE_W     = 8;
  localparam int BITS_W     = 8;
  localparam int GROW_W     = 4;
  localparam int POS_W      = 12;
  localparam int COLOUR_W   = 32;
  localparam int ADDR_W     = 25;
  localparam int PITCH_W    = 14;
  localparam int SWIDTH_W   = 13;
  localparam int CFG_IDX_W  = 2;
  localparam int DRAW_ROWS  = 16;
  localparam int DRAW_ROW_W = $clog2(DRAW_ROWS);
  localparam int GLYPH_W    = 8;
  localparam int LINE_H     = 16;

  localparam logic [PITCH_W-1:0]  PITCH_RST  = PITCH_W'(1024);
  localparam logic [SWIDTH_W-1:0] SWIDTH_RST = SWIDTH_W'(1024);

  typedef enum logic [1:0] {
    REQ_LOAD    = 2'd0,
    REQ_DRAW    = 2'd1,
    REQ_CURSOR  = 2'd2,
    REQ_NEWLINE = 2'd3
  } req_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LINE_PITCH   = CFG_IDX_W'(0),
    REG_SCREEN_WIDTH = CFG_IDX_W'(1)
  } cfg_reg_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MUL,
    ST_ADD,
    ST_ROWS
  } state_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic load_font;
    logic set_cursor;
    logic newline;
    logic start_draw;
    logic mul;
    logic add;
    logic emit_row;
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic out_free;
    logic row_last;
  } status_t;

  // Entry of row r of glyph c: c * GLYPH_ROWS + r, wrapped to the store depth.
  function automatic logic [FONT_AW-1:0] font_index(logic [CODE_W-1:0] code,
                                                    logic [DRAW_ROW_W-1:0] row);
    logic [31:0] sum;
    sum = 32'(code) * 32'(GLYPH_ROWS) + 32'(row);
    return sum[FONT_AW-1:0];
  endfunction

endpackage

### rtl/bftr_ctrl.sv
// Controller state machine of the bitmap font text renderer.
// Depends on bftr_pkg for the state, request and command types.
module bftr_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic [1:0]           req_type_i,
  output logic                 in_stall_o,
  input  bftr_pkg::status_t    status_i,
  output bftr_pkg::cmd_t       cmd_o
);

  bftr_pkg::state_e state_q, state_d;
  bftr_pkg::req_e   req;

  assign req = bftr_pkg::req_e'(req_type_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= bftr_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_stall_o = 1'b1;
    case (state_q)
      bftr_pkg::ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          case (req)
            bftr_pkg::REQ_LOAD:    cmd_o.load_font  = 1'b1;
            bftr_pkg::REQ_CURSOR:  cmd_o.set_cursor = 1'b1;
            bftr_pkg::REQ_NEWLINE: cmd_o.newline    = 1'b1;
            bftr_pkg::REQ_DRAW: begin
              cmd_o.start_draw = 1'b1;
              state_d          = bftr_pkg::ST_MUL;
            end
            default: ;
          endcase
        end
      end
      bftr_pkg::ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = bftr_pkg::ST_ADD;
      end
      bftr_pkg::ST_ADD: begin
        cmd_o.add = 1'b1;
        state_d   = bftr_pkg::ST_ROWS;
      end
      bftr_pkg::ST_ROWS: begin
        if (status_i.out_free) begin
          cmd_o.emit_row = 1'b1;
          if (status_i.row_last) begin
            state_d = bftr_pkg::ST_IDLE;
          end
        end
      end
      default: state_d = bftr_pkg::ST_IDLE;
    endcase
  end

endmodule

### rtl/bftr_dp.sv
// Datapath of the bitmap font text renderer: config registers, cursor, font
// memory, row address accumulator and output register. Depends on bftr_pkg.
module bftr_dp (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  bftr_pkg::cmd_t                         cmd_i,
  output bftr_pkg::status_t                      status_o,
  input  logic                                   cfg_we_i,
  input  logic [bftr_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [bftr_pkg::PITCH_W-1:0]           cfg_data_i,
  input  logic [bftr_pkg::CODE_W-1:0]            char_code_i,
  input  logic [bftr_pkg::GROW_W-1:0]            glyph_row_i,
  input  logic [bftr_pkg::BITS_W-1:0]            row_bits_i,
  input  logic [bftr_pkg::POS_W-1:0]             pos_x_i,
  input  logic [bftr_pkg::POS_W-1:0]             pos_y_i,
  input  logic [bftr_pkg::COLOUR_W-1:0]          colour_i,
  input  logic                                   out_stall_i,
  output logic                                   out_valid_o,
  output logic [bftr_pkg::ADDR_W-1:0]            pixel_addr_o,
  output logic [bftr_pkg::BITS_W-1:0]            pixel_mask_o,
  output logic [bftr_pkg::COLOUR_W-1:0]          pixel_colour_o,
  output logic                                   last_row_o
);

  localparam int PROD_W = bftr_pkg::POS_W + bftr_pkg::PITCH_W;

  logic [bftr_pkg::BITS_W-1:0]     font_mem [bftr_pkg::FONT_DEPTH];

  logic [bftr_pkg::PITCH_W-1:0]    pitch_q;
  logic [bftr_pkg::SWIDTH_W-1:0]   swidth_q;
  logic [bftr_pkg::POS_W-1:0]      cur_x_q, cur_y_q;
  logic [bftr_pkg::CODE_W-1:0]     code_q;
  logic [bftr_pkg::COLOUR_W-1:0]   colour_q;
  logic [bftr_pkg::ADDR_W-1:0]     prod_q;
  logic [bftr_pkg::ADDR_W-1:0]     acc_q;
  logic [bftr_pkg::DRAW_ROW_W-1:0] row_q;
  logic                            out_valid_q;
  logic [bftr_pkg::ADDR_W-1:0]     out_addr_q;
  logic [bftr_pkg::BITS_W-1:0]     mask_q;
  logic [bftr_pkg::COLOUR_W-1:0]   out_colour_q;
  logic                            out_last_q;

  logic [PROD_W-1:0]               prod_full;
  logic [bftr_pkg::POS_W:0]        next_x;
  logic [bftr_pkg::POS_W+1:0]      next_edge;
  logic                            wrap;
  logic [bftr_pkg::FONT_AW-1:0]    wr_idx, rd_idx;
  logic                            out_free;
  logic                            row_last;

  assign prod_full = PROD_W'(cur_y_q) * PROD_W'(pitch_q);
  assign next_x    = {1'b0, cur_x_q} + (bftr_pkg::POS_W+1)'(bftr_pkg::GLYPH_W);
  assign next_edge = {1'b0, next_x} + (bftr_pkg::POS_W+2)'(bftr_pkg::GLYPH_W);
  assign wrap      = next_edge > (bftr_pkg::POS_W+2)'(swidth_q);

  assign wr_idx = bftr_pkg::font_index(char_code_i,
                    bftr_pkg::DRAW_ROW_W'(glyph_row_i[bftr_pkg::ROW_W-1:0]));
  assign rd_idx = bftr_pkg::font_index(code_q, row_q);

  assign out_free = !out_valid_q || !out_stall_i;
  assign row_last = row_q == bftr_pkg::DRAW_ROW_W'(bftr_pkg::DRAW_ROWS - 1);

  assign status_o.out_free = out_free;
  assign status_o.row_last = row_last;

  // Font memory: one write port for loads, one registered read port for rows.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_font) begin
      font_mem[wr_idx] <= row_bits_i;
    end
    if (cmd_i.emit_row) begin
      mask_q <= font_mem[rd_idx];
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (cmd_i.start_draw) begin
      code_q   <= char_code_i;
      colour_q <= colour_i;
    end
    if (cmd_i.mul) begin
      prod_q <= prod_full[bftr_pkg::ADDR_W-1:0];
    end
    if (cmd_i.add) begin
      acc_q <= prod_q + bftr_pkg::ADDR_W'(cur_x_q);
    end else if (cmd_i.emit_row) begin
      acc_q <= acc_q + bftr_pkg::ADDR_W'(pitch_q);
    end
    if (cmd_i.emit_row) begin
      out_addr_q   <= acc_q;
      out_colour_q <= colour_q;
      out_last_q   <= row_last;
    end
  end

  // Control and architectural state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pitch_q     <= bftr_pkg::PITCH_RST;
      swidth_q    <= bftr_pkg::SWIDTH_RST;
      cur_x_q     <= '0;
      cur_y_q     <= '0;
      row_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (bftr_pkg::cfg_reg_e'(cfg_index_i))
          bftr_pkg::REG_LINE_PITCH:   pitch_q  <= cfg_data_i;
          bftr_pkg::REG_SCREEN_WIDTH: swidth_q <= cfg_data_i[bftr_pkg::SWIDTH_W-1:0];
          default: ;
        endcase
      end
      if (cmd_i.set_cursor) begin
        cur_x_q <= pos_x_i;
        cur_y_q <= pos_y_i;
      end else if (cmd_i.newline || (cmd_i.add && wrap)) begin
        cur_x_q <= '0;
        cur_y_q <= cur_y_q + bftr_pkg::POS_W'(bftr_pkg::LINE_H);
      end else if (cmd_i.add) begin
        cur_x_q <= next_x[bftr_pkg::POS_W-1:0];
      end
      if (cmd_i.start_draw) begin
        row_q <= '0;
      end else if (cmd_i.emit_row) begin
        row_q <= row_q + 1'b1;
      end
      if (out_free) begin
        out_valid_q <= cmd_i.emit_row;
      end
    end
  end

  assign out_valid_o    = out_valid_q;
  assign pixel_addr_o   = out_addr_q;
  assign pixel_mask_o   = mask_q;
  assign pixel_colour_o = out_colour_q;
  assign last_row_o     = out_last_q;

endmodule

### rtl/bitmap_font_text_renderer.sv
// Top level of the bitmap font text renderer for an 8x16 bitmap font.
// Depends on bftr_pkg, bftr_ctrl and bftr_dp.
// - Input channel (in_valid_i / in_stall_o) takes one request item per
//   handshake: load a font row byte, draw a character, set the cursor, or
//   start a new text line. Load, cursor and newline items keep the block idle.
// - A draw item passes a row multiply state (cursor_y * line_pitch), then an
//   add state that adds cursor_x and advances the cursor, then streams 16
//   row writes from the font memory read port, one per cycle while the
//   output is not stalled. The controller takes the next item once it is
//   back in idle, which it enters at the edge that loads the sixteenth row
//   into the output register.
// - Output channel (out_valid_o / out_stall_i) carries the row writes:
//   pixel index of the leftmost pixel, mask (bit 7 leftmost), colour, and
//   last_row_o on the sixteenth row. The output register holds its item
//   while out_stall_i is high, and the row stream pauses with it.
// - Config channel (cfg_valid_i / cfg_ready_o) writes line_pitch (index 0)
//   or screen_width (index 1); other indexes are dropped. Write only while
//   the block is idle. cfg_ready_o is always high.
// - Reset clears the cursor to zero and sets both registers to 1024. The
//   font memory is not cleared; draw only glyph rows that were loaded.
module bitmap_font_text_renderer (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  // config write channel
  input  logic                                   cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  logic [bftr_pkg::CFG_IDX_W-1:0]         cfg_index_i,
  input  logic [bftr_pkg::PITCH_W-1:0]           cfg_data_i,
  // request channel
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic [1:0]                             req_type_i,
  input  logic [bftr_pkg::CODE_W-1:0]            char_code_i,
  input  logic [bftr_pkg::GROW_W-1:0]            glyph_row_i,
  input  logic [bftr_pkg::BITS_W-1:0]            row_bits_i,
  input  logic [bftr_pkg::POS_W-1:0]             pos_x_i,
  input  logic [bftr_pkg::POS_W-1:0]             pos_y_i,
  input  logic [bftr_pkg::COLOUR_W-1:0]          colour_i,
  // row write channel
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic [bftr_pkg::ADDR_W-1:0]            pixel_addr_o,
  output logic [bftr_pkg::BITS_W-1:0]            pixel_mask_o,
  output logic [bftr_pkg::COLOUR_W-1:0]          pixel_colour_o,
  output logic                                   last_row_o
);

  bftr_pkg::cmd_t    cmd;
  bftr_pkg::status_t status;

  // Config registers never back-pressure.
  assign cfg_ready_o = 1'b1;

  // Sequence request items and the row stream.
  bftr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .req_type_i (req_type_i),
    .in_stall_o (in_stall_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  // Hold font, cursor and registers; build each row write.
  bftr_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .cfg_we_i       (cfg_valid_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .char_code_i    (char_code_i),
    .glyph_row_i    (glyph_row_i),
    .row_bits_i     (row_bits_i),
    .pos_x_i        (pos_x_i),
    .pos_y_i        (pos_y_i),
    .colour_i       (colour_i),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .pixel_addr_o   (pixel_addr_o),
    .pixel_mask_o   (pixel_mask_o),
    .pixel_colour_o (pixel_colour_o),
    .last_row_o     (last_row_o)
  );

endmodule

### rtl/bftr_checker.sv
// Port-level checks for the bitmap font text renderer, bound to the top level.
// Depends on bftr_pkg for field widths and request codes.
module bftr_checker (
  input logic                              clk_i,
  input logic                              rst_ni,
  input logic                              in_valid_i,
  input logic                              in_stall_o,
  input logic [1:0]                        req_type_i,
  input logic                              out_valid_o,
  input logic                              out_stall_i,
  input logic [bftr_pkg::ADDR_W-1:0]       pixel_addr_o,
  input logic [bftr_pkg::BITS_W-1:0]       pixel_mask_o,
  input logic [bftr_pkg::COLOUR_W-1:0]     pixel_colour_o,
  input logic                              last_row_o
);

  // No row write shows in the cycle after reset is seen.
  assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("row write valid after reset");

  // A stalled row write holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(pixel_addr_o) &&
      $stable(pixel_mask_o) && $stable(pixel_colour_o) && $stable(last_row_o))
    else $error("stalled row write changed");

  // A row other than the last one means the draw is still running.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_row_o |-> in_stall_o)
    else $error("request taken in the middle of a draw");

  // An accepted draw blocks the request channel in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && req_type_i == bftr_pkg::REQ_DRAW |=> in_stall_o)
    else $error("draw did not block the request channel");

  // Rows of one character follow without bubbles.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_row_o |=> out_valid_o)
    else $error("gap in the row stream");

endmodule

bind bitmap_font_text_renderer bftr_checker u_bftr_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_valid_i),
  .in_stall_o     (in_stall_o),
  .req_type_i     (req_type_i),
  .out_valid_o    (out_valid_o),
  .out_stall_i    (out_stall_i),
  .pixel_addr_o   (pixel_addr_o),
  .pixel_mask_o   (pixel_mask_o),
  .pixel_colour_o (pixel_colour_o),
  .last_row_o     (last_row_o)
);
